// ----- hw/rtl/sta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants of the slot table allocator.
// ----------------------------------------------------------------------------
package sta_pkg;

	localparam int SLOT_COUNT_DEF  = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	localparam int CFG_W        = 7;
	localparam int ACTION_W     = 3;
	localparam int IDX_PORT_W   = 8;
	localparam int VALUE_PORT_W = 64;
	localparam int GRANT_W      = 6;
	localparam int STATUS_W     = 2;

	localparam int GROUP_SIZE = 16;
	localparam int OFF_W      = $clog2(GROUP_SIZE);

	typedef enum logic [ACTION_W-1:0] {
		ACT_ADD    = 3'd0,
		ACT_SET    = 3'd1,
		ACT_GET    = 3'd2,
		ACT_REMOVE = 3'd3,
		ACT_CHECK  = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_UNCLAIMED = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

endpackage

// ----- hw/rtl/slot_table_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_allocator_core
// Slot table with claimed bits: add, set, get, remove and check requests.
//
// Request channel (req_valid / req_stall) carries action, slot_index and
// write_value; every request gives exactly one response on the response
// channel (rsp_valid / rsp_stall) with status, granted_index, read_value and
// is_claimed. The cfg channel (cfg_valid / cfg_ready) grows slots_in_use;
// smaller writes are ignored, larger ones saturate at SLOT_COUNT. Write it
// only while no request is in flight.
// The request is taken into the stage-1 registers; the response is registered
// in the output register when the execute state commits. A new request is
// taken only after the current one commits, set by the registered read of
// the value memory, the write-back and the registered free-slot search level.
// Reset clears all claimed bits and sets slots_in_use to min(64, SLOT_COUNT);
// values are not cleared. A stalled response holds in the output register;
// one further request is taken and completes when the register frees.
// ----------------------------------------------------------------------------
module slot_table_allocator_core #(
	parameter int SLOT_COUNT  = sta_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_WIDTH = sta_pkg::VALUE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sta_pkg::CFG_W-1:0]        cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [sta_pkg::ACTION_W-1:0]     action,
	input  logic [sta_pkg::IDX_PORT_W-1:0]   slot_index,
	input  logic [sta_pkg::VALUE_PORT_W-1:0] write_value,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [sta_pkg::STATUS_W-1:0]     status,
	output logic [sta_pkg::GRANT_W-1:0]      granted_index,
	output logic [sta_pkg::VALUE_PORT_W-1:0] read_value,
	output logic                            is_claimed
);
	import sta_pkg::*;

	localparam int IDX_W       = $clog2(SLOT_COUNT);
	localparam int RESET_SLOTS = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
	localparam int CMP_W       = IDX_PORT_W + 1;

	state_t state_q, state_d;

	logic [CFG_W-1:0]      slots_q;
	logic [SLOT_COUNT-1:0] claimed_q;
	logic [SLOT_COUNT-1:0] usable;
	logic [SLOT_COUNT-1:0] free_vec;

	logic [VALUE_WIDTH-1:0] mem [SLOT_COUNT];
	logic [VALUE_WIDTH-1:0] rd_data_s1;

	action_t                act_s1;
	logic [IDX_PORT_W-1:0]  idx_s1;
	logic [VALUE_WIDTH-1:0] data_s1;

	logic                  found;
	logic [IDX_PORT_W-1:0] free_slot;

	logic                   req_take;
	logic                   out_free;
	logic                   commit;
	logic                   in_range;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   claim_we;
	logic [IDX_W-1:0]       claim_addr;
	logic                   claim_val;

	status_t                 rsp_status;
	logic [GRANT_W-1:0]      rsp_grant;
	logic [VALUE_PORT_W-1:0] rsp_value;
	logic                    rsp_claimed;

	logic                    rsp_valid_q;
	status_t                 status_q;
	logic [GRANT_W-1:0]      granted_q;
	logic [VALUE_PORT_W-1:0] read_value_q;
	logic                    is_claimed_q;

	assign cfg_ready     = 1'b1;
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign read_value    = read_value_q;
	assign is_claimed    = is_claimed_q;

	assign req_take = req_valid && !req_stall;
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			usable[i] = CMP_W'(i) < CMP_W'(slots_q);
		end
	end

	assign free_vec = usable & ~claimed_q;

	sta_free_search #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_search (
		.clk      (clk),
		.capture  (req_take),
		.free_vec (free_vec),
		.found    (found),
		.slot     (free_slot)
	);

	// slots_in_use register: grow only, saturate at SLOT_COUNT
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= CFG_W'(RESET_SLOTS);
		end else if (cfg_valid && cfg_ready) begin
			if (CMP_W'(cfg_data) > CMP_W'(SLOT_COUNT)) begin
				if (CMP_W'(SLOT_COUNT) > CMP_W'(slots_q)) begin
					slots_q <= CFG_W'(SLOT_COUNT);
				end
			end else if (cfg_data > slots_q) begin
				slots_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		commit    = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			act_s1     <= action_t'(action);
			idx_s1     <= slot_index;
			data_s1    <= write_value[VALUE_WIDTH-1:0];
			rd_data_s1 <= mem[slot_index[IDX_W-1:0]];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	assign in_range = CMP_W'(idx_s1) < CMP_W'(slots_q);

	always_comb begin
		rsp_status  = ST_OK;
		rsp_grant   = '0;
		rsp_value   = '0;
		rsp_claimed = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = idx_s1[IDX_W-1:0];
		mem_wdata   = data_s1;
		claim_we    = 1'b0;
		claim_addr  = idx_s1[IDX_W-1:0];
		claim_val   = 1'b1;
		case (act_s1)
			ACT_ADD: begin
				if (found) begin
					mem_we     = commit;
					mem_waddr  = free_slot[IDX_W-1:0];
					claim_we   = commit;
					claim_addr = free_slot[IDX_W-1:0];
					rsp_grant  = free_slot[GRANT_W-1:0];
				end else begin
					rsp_status = ST_FULL;
				end
			end
			ACT_SET: begin
				if (in_range) begin
					mem_we   = commit;
					claim_we = commit;
				end else begin
					rsp_status = ST_RANGE;
				end
			end
			ACT_GET: begin
				if (!in_range) begin
					rsp_status = ST_RANGE;
				end else if (!claimed_q[idx_s1[IDX_W-1:0]]) begin
					rsp_status = ST_UNCLAIMED;
				end else begin
					rsp_value = VALUE_PORT_W'(rd_data_s1);
				end
			end
			ACT_REMOVE: begin
				if (in_range) begin
					mem_we    = commit;
					mem_wdata = '0;
					claim_we  = commit;
					claim_val = 1'b0;
				end else begin
					rsp_status = ST_RANGE;
				end
			end
			ACT_CHECK: begin
				if (in_range) begin
					rsp_claimed = claimed_q[idx_s1[IDX_W-1:0]];
				end else begin
					rsp_status = ST_RANGE;
				end
			end
			default: begin
				rsp_status = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claimed_q <= '0;
		end else if (claim_we) begin
			claimed_q[claim_addr] <= claim_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q     <= rsp_status;
			granted_q    <= rsp_grant;
			read_value_q <= rsp_value;
			is_claimed_q <= rsp_claimed;
		end
	end

	a_claimed_usable: assert property (@(posedge clk) disable iff (!arst_n)
		(claimed_q & ~usable) == '0)
		else $error("claimed bit set outside usable slots");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && act_s1 == ACT_ADD && found) |-> !claimed_q[free_slot[IDX_W-1:0]])
		else $error("add granted a claimed slot");

	a_slots_grow: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> slots_q >= $past(slots_q))
		else $error("slots_in_use shrank");

	a_rsp_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EXEC))
		else $error("response raised outside execute state");

endmodule

// ----- hw/rtl/sta_free_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_free_search
// Two-level lowest-free-slot search: per-group encoders, registered, then a
// priority pick over the groups.
// ----------------------------------------------------------------------------
module sta_free_search #(
	parameter int SLOT_COUNT = sta_pkg::SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          capture,
	input  logic [SLOT_COUNT-1:0]         free_vec,
	output logic                          found,
	output logic [sta_pkg::IDX_PORT_W-1:0] slot
);
	import sta_pkg::*;

	localparam int NGROUP = (SLOT_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_W  = NGROUP * GROUP_SIZE;

	logic [PAD_W-1:0]  padded;
	logic [NGROUP-1:0] grp_any;
	logic [OFF_W-1:0]  grp_off [NGROUP];
	logic [NGROUP-1:0] grp_any_s1;
	logic [OFF_W-1:0]  grp_off_s1 [NGROUP];

	always_comb begin
		padded = '0;
		padded[SLOT_COUNT-1:0] = free_vec;
		for (int g = 0; g < NGROUP; g++) begin
			grp_any[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
			grp_off[g] = '0;
			for (int o = GROUP_SIZE - 1; o >= 0; o--) begin
				if (padded[g*GROUP_SIZE + o]) begin
					grp_off[g] = OFF_W'(o);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			grp_any_s1 <= grp_any;
			grp_off_s1 <= grp_off;
		end
	end

	always_comb begin
		found = |grp_any_s1;
		slot  = '0;
		for (int g = NGROUP - 1; g >= 0; g--) begin
			if (grp_any_s1[g]) begin
				slot = IDX_PORT_W'(g * GROUP_SIZE) + IDX_PORT_W'(grp_off_s1[g]);
			end
		end
	end

endmodule
